FILE: design/emb_pkg.sv
// Shared constants, command codes and dictionary interface types for the macro expander.
`timescale 1ns / 1ps
`default_nettype none

package emb_pkg;

    localparam int ENTRIES       = 64;
    localparam int MAX_MACRO_LEN = 32;

    localparam int ENTRY_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int STORE_DEPTH = ENTRIES * MAX_MACRO_LEN;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int LEN_W       = $clog2(MAX_MACRO_LEN + 1);
    localparam int COUNT_W     = 9;
    localparam int PADDR_W     = 2;

    localparam logic [7:0] ESCAPE_BYTE = 8'hC0;

    localparam logic [1:0] CMD_STREAM     = 2'd0;
    localparam logic [1:0] CMD_WRITE_BYTE = 2'd1;
    localparam logic [1:0] CMD_SET_LEN    = 2'd2;

    localparam logic [PADDR_W-1:0] ADDR_MACRO_COUNT = PADDR_W'(0);

    typedef struct packed {
        logic              byte_we;
        logic [ADDR_W-1:0] byte_waddr;
        logic [7:0]        byte_wdata;
        logic              byte_re;
        logic [ADDR_W-1:0] byte_raddr;
        logic              len_we;
        logic [ENTRY_W-1:0] len_waddr;
        logic [LEN_W-1:0]  len_wdata;
        logic              len_re;
        logic [ENTRY_W-1:0] len_raddr;
    } dict_req_t;

    typedef struct packed {
        logic [7:0]       byte_rd;
        logic [LEN_W-1:0] len_rd;
        logic             valid_rd;
    } dict_rsp_t;

endpackage

`default_nettype wire

FILE: design/emb_dict.sv
// Macro dictionary: byte store, length store and per-entry valid marks.
`timescale 1ns / 1ps
`default_nettype none

module emb_dict
    import emb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire dict_req_t req,
    output dict_rsp_t      rsp
);

    logic [7:0]       byte_mem [STORE_DEPTH];
    logic [LEN_W-1:0] len_mem  [ENTRIES];
    logic             valid_reg [ENTRIES];

    logic [7:0]       byte_rd_reg;
    logic [LEN_W-1:0] len_rd_reg;
    logic             valid_rd_reg;

    always_ff @(posedge clk)
    begin
        if (req.byte_we)
        begin
            byte_mem[req.byte_waddr] <= req.byte_wdata;
        end
        if (req.byte_re)
        begin
            byte_rd_reg <= byte_mem[req.byte_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.len_we)
        begin
            len_mem[req.len_waddr] <= req.len_wdata;
        end
        if (req.len_re)
        begin
            len_rd_reg   <= len_mem[req.len_raddr];
            valid_rd_reg <= valid_reg[req.len_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (req.len_we)
        begin
            valid_reg[req.len_waddr] <= 1'b1;
        end
    end

    assign rsp.byte_rd  = byte_rd_reg;
    assign rsp.len_rd   = len_rd_reg;
    assign rsp.valid_rd = valid_rd_reg;

endmodule

`default_nettype wire

FILE: design/emb_seq.sv
// Sequencer: decodes items, resolves escapes and streams macro bytes to the output register.
`timescale 1ns / 1ps
`default_nettype none

module emb_seq
    import emb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [COUNT_W-1:0] macro_count,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         cmd,
    input  wire logic [7:0]         data_byte,
    input  wire logic [5:0]         entry,
    input  wire logic [4:0]         position,
    input  wire logic [5:0]         length,
    input  wire logic               last,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [7:0]              out_byte,
    output logic                    run_last,
    output dict_req_t               req,
    input  wire dict_rsp_t          rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_RD,
        S_EMIT,
        S_ESC,
        S_PLAIN
    } state_t;

    state_t           state_reg, state_next;
    logic             pending_reg, pending_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;
    logic [LEN_W-1:0] k_reg, k_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             run_last_reg, run_last_next;

    logic             out_free;
    logic             plain_pends;
    logic             hit;
    logic [LEN_W-1:0] k_inc;
    logic             entry_ok;

    assign out_free    = !out_valid_reg || !out_stall;
    assign plain_pends = (byte_reg == ESCAPE_BYTE) && !last_reg;
    assign hit         = ({1'b0, byte_reg} < macro_count) && (int'(byte_reg) < ENTRIES)
                         && rsp.valid_rd;
    assign k_inc       = k_reg + LEN_W'(1);
    assign entry_ok    = int'(entry) < ENTRIES;

    always_comb
    begin
        state_next     = state_reg;
        pending_next   = pending_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        k_next         = k_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        run_last_next  = run_last_reg;

        req            = '0;
        req.byte_waddr = ADDR_W'(int'(entry) * MAX_MACRO_LEN + int'(position));
        req.byte_wdata = data_byte;
        req.len_waddr  = ENTRY_W'(entry);
        req.len_wdata  = (int'(length) > MAX_MACRO_LEN) ? LEN_W'(MAX_MACRO_LEN)
                                                        : LEN_W'(length);
        req.len_raddr  = ENTRY_W'(data_byte);
        req.byte_raddr = ADDR_W'(int'(byte_reg) * MAX_MACRO_LEN + int'(k_reg));

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (cmd)
                        CMD_WRITE_BYTE:
                        begin
                            req.byte_we = entry_ok && (int'(position) < MAX_MACRO_LEN);
                        end
                        CMD_SET_LEN:
                        begin
                            req.len_we = entry_ok;
                        end
                        CMD_STREAM:
                        begin
                            byte_next  = data_byte;
                            last_next  = last;
                            req.len_re = 1'b1;
                            state_next = S_DECIDE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DECIDE:
            begin
                if (pending_reg && hit)
                begin
                    pending_next = 1'b0;
                    len_next     = rsp.len_rd;
                    k_next       = '0;
                    state_next   = (rsp.len_rd == '0) ? S_IDLE : S_RD;
                end
                else if (pending_reg)
                begin
                    state_next = S_ESC;
                end
                else if (plain_pends)
                begin
                    pending_next = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    state_next = S_PLAIN;
                end
            end
            S_RD:
            begin
                req.byte_re = 1'b1;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = rsp.byte_rd;
                    run_last_next  = (k_inc == len_reg);
                    k_next         = k_inc;
                    state_next     = (k_inc == len_reg) ? S_IDLE : S_RD;
                end
            end
            S_ESC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = ESCAPE_BYTE;
                    run_last_next  = plain_pends;
                    // index byte is itself an escape: it stays pending
                    state_next     = plain_pends ? S_IDLE : S_PLAIN;
                end
            end
            S_PLAIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = byte_reg;
                    run_last_next  = 1'b1;
                    pending_next   = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            byte_reg      <= '0;
            last_reg      <= 1'b0;
            k_reg         <= '0;
            len_reg       <= '0;
            out_byte_reg  <= '0;
            run_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
            byte_reg      <= byte_next;
            last_reg      <= last_next;
            k_reg         <= k_next;
            len_reg       <= len_next;
            out_byte_reg  <= out_byte_next;
            run_last_reg  <= run_last_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;

endmodule

`default_nettype wire

FILE: design/escape_macro_byte_expander.sv
// Top level of the escape-prefixed macro byte expander with its register port.
//
// Expands a byte stream where 0xC0 plus an index byte stands for a dictionary macro.
// Command items (write byte, set length) leave the block ready again at once. A stream
// item is accepted, then resolved in a decide state; a literal result then goes to the
// output register once it is free, and an unmatched escape sends the escape byte ahead
// of the second byte, unless that byte is itself an escape that stays pending. A macro's
// bytes are read one at a time: each is a registered read of the byte store, then an emit
// that waits for a free output register. Stores need no clearing after reset; only the
// valid marks are reset. macro_count sits at address 0 of the register port.
`timescale 1ns / 1ps
`default_nettype none

module escape_macro_byte_expander
    import emb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         cmd,
    input  wire logic [7:0]         data_byte,
    input  wire logic [5:0]         entry,
    input  wire logic [4:0]         position,
    input  wire logic [5:0]         length,
    input  wire logic               last,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [7:0]              out_byte,
    output logic                    run_last
);

    logic [COUNT_W-1:0] macro_count_reg, macro_count_next;
    dict_req_t          req;
    dict_rsp_t          rsp;

    assign pready = 1'b1;

    always_comb
    begin
        macro_count_next = macro_count_reg;
        if (psel && penable && pwrite && (paddr == ADDR_MACRO_COUNT))
        begin
            macro_count_next = pwdata[COUNT_W-1:0];
        end
        prdata = (paddr == ADDR_MACRO_COUNT) ? 32'(macro_count_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            macro_count_reg <= '0;
        end
        else
        begin
            macro_count_reg <= macro_count_next;
        end
    end

    emb_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .macro_count (macro_count_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .entry       (entry),
        .position    (position),
        .length      (length),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .req         (req),
        .rsp         (rsp)
    );

    emb_dict u_dict (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

FILE: design/emb_checker.sv
// Port-level checks for the macro expander, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module emb_checker
    import emb_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       pready,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic [1:0] cmd,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] out_byte,
    input wire logic       run_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(run_last))
        else $error("stalled result changed");

    // a stream transfer always keeps the block busy for at least the resolve cycle
    a_stream_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (cmd == CMD_STREAM) |=> in_stall)
        else $error("stream item not resolved");

    // command items complete in the cycle they are taken
    a_cmd_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (cmd != CMD_STREAM) |=> !in_stall)
        else $error("command item held the input");

    // while more results of an item are due, no new item is taken
    a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |-> in_stall)
        else $error("input taken in the middle of a run");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

endmodule

bind escape_macro_byte_expander emb_checker u_emb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .run_last  (run_last)
);

`default_nettype wire

FILE: tb/escape_macro_byte_expander_checker.sv
// Checker for the macro byte expander: tracks register and dictionary, predicts and compares bytes.
`timescale 1ns / 1ps

module escape_macro_byte_expander_checker
    import emb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [7:0]         data_byte,
    input  logic [5:0]         entry,
    input  logic [4:0]         position,
    input  logic [5:0]         length,
    input  logic               last,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [7:0]         out_byte,
    input  logic               run_last,
    output int                 mismatch_count,
    output int                 bytes_pending
);

    typedef struct packed {
        logic [7:0] value;
        logic       tail;
    } out_beat_t;

    out_beat_t          expected_bytes[$];
    out_beat_t          want;
    logic [COUNT_W-1:0] macro_count;
    logic               escape_open;
    logic [7:0]         dict_bytes [STORE_DEPTH];
    int                 dict_len [ENTRIES];
    logic               dict_valid [ENTRIES];

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] wanted);
        $display("%0t: mismatch on %s: got %02h, expected %02h", $time, what, got, wanted);
        mismatch_count++;
    endtask

    // Apply one accepted input transfer and queue the bytes it expands to.
    task automatic expand_item(input logic [1:0] c, input logic [7:0] b, input logic [5:0] ent,
                               input logic [4:0] pos, input logic [5:0] len, input logic lst);
        logic [7:0] run[$];
        int         base;
        int         k;
        case (c)
            CMD_WRITE_BYTE: dict_bytes[int'(ent) * MAX_MACRO_LEN + int'(pos)] = b;
            CMD_SET_LEN: begin
                dict_len[ent]   = (len > MAX_MACRO_LEN) ? MAX_MACRO_LEN : int'(len);
                dict_valid[ent] = 1'b1;
            end
            CMD_STREAM: begin
                if (escape_open && b < macro_count && b < ENTRIES
                    && dict_valid[b[ENTRY_W-1:0]]) begin
                    escape_open = 1'b0;
                    base = int'(b) * MAX_MACRO_LEN;
                    for (k = 0; k < dict_len[b[ENTRY_W-1:0]]; k++)
                        run.push_back(dict_bytes[base + k]);
                end
                else begin
                    // unknown index: escape goes out alone, index byte starts over
                    if (escape_open)
                        run.push_back(ESCAPE_BYTE);
                    escape_open = (b == ESCAPE_BYTE) && !lst;
                    if (!escape_open)
                        run.push_back(b);
                end
            end
            default: ;
        endcase
        foreach (run[i])
            expected_bytes.push_back(out_beat_t'{value: run[i], tail: (i == run.size() - 1)});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_bytes.delete();
            macro_count    = '0;
            escape_open    = 1'b0;
            mismatch_count = 0;
            foreach (dict_valid[i])
                dict_valid[i] = 1'b0;
            bytes_pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_MACRO_COUNT)
                macro_count = pwdata[COUNT_W-1:0];
            // results are checked before this edge's input is predicted
            if (out_valid && !out_stall)
            begin
                if (expected_bytes.size() == 0)
                    report_mismatch("transfer with nothing expected, out_byte", out_byte, 8'h00);
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_byte !== want.value)
                        report_mismatch("out_byte", out_byte, want.value);
                    if (run_last !== want.tail)
                        report_mismatch("run_last", {7'b0, run_last}, {7'b0, want.tail});
                end
            end
            if (in_valid && !in_stall)
                expand_item(cmd, data_byte, entry, position, length, last);
            bytes_pending <= expected_bytes.size();
        end
    end

endmodule

FILE: tb/tb_escape_macro_byte_expander.sv
// Testbench top for the macro byte expander: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_escape_macro_byte_expander;
    import emb_pkg::*;

    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    localparam int         SETTLE_CYCLES = 100;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         PHASES        = 5;
    localparam int         PHASE_ITEMS   = 80;
    localparam int         PREFILL_DEFS  = 4;

    localparam logic [COUNT_W-1:0] PHASE_COUNT [PHASES] = '{9'd256, 9'd33, 9'd1, 9'd200, 9'd64};
    localparam int                 PHASE_IDLE  [PHASES] = '{2, 3, 0, 1, 0};

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         cmd;
    logic [7:0]         data_byte;
    logic [5:0]         entry;
    logic [4:0]         position;
    logic [5:0]         length;
    logic               last;
    logic               out_valid;
    logic               out_stall;
    logic [7:0]         out_byte;
    logic               run_last;
    int                 mismatch_count;
    int                 bytes_pending;

    int                   idle_level = 0;
    bit                   hold_req = 1'b0;
    int                   items_sent = 0;
    logic [COUNT_W-1:0]   cur_count = '0;
    logic [MAX_MACRO_LEN-1:0] byte_written [ENTRIES];

    escape_macro_byte_expander u_top (.*);

    escape_macro_byte_expander_checker u_checker (.*);

    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        #12_000_000;
        $display("tb_escape_macro_byte_expander failed");
        $finish;
    end

    // Receiver side: random stall bursts, plus one long hold-off on request.
    initial
    begin
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (idle_level > 0 && $urandom_range(0, 7) < idle_level)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic push_item(input logic [1:0] c, input logic [7:0] b, input logic [5:0] ent,
                             input logic [4:0] pos, input logic [5:0] len, input logic lst);
        in_valid  <= 1'b1;
        cmd       <= c;
        data_byte <= b;
        entry     <= ent;
        position  <= pos;
        length    <= len;
        last      <= lst;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (c != CMD_UNUSED)
            items_sent++;
        if (idle_level > 0 && $urandom_range(0, 7) < idle_level)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic stream_byte(input logic [7:0] b, input logic lst);
        push_item(CMD_STREAM, b, 6'($urandom), 5'($urandom), 6'($urandom), lst);
    endtask

    task automatic write_macro_byte(input logic [5:0] ent, input logic [4:0] pos,
                                    input logic [7:0] b);
        push_item(CMD_WRITE_BYTE, b, ent, pos, 6'($urandom), 1'($urandom));
        byte_written[ent][pos] = 1'b1;
    endtask

    // Every byte below the (saturated) length is written before the entry turns valid,
    // so an expansion never reads a byte that was never stored.
    task automatic define_macro(input logic [5:0] ent, input logic [5:0] len);
        int fill;
        int k;
        fill = (len > MAX_MACRO_LEN) ? MAX_MACRO_LEN : int'(len);
        for (k = 0; k < fill; k++)
            if (!byte_written[ent][k])
                write_macro_byte(ent, 5'(k), 8'($urandom));
        push_item(CMD_SET_LEN, 8'($urandom), ent, 5'($urandom), len, 1'($urandom));
    endtask

    // Wait until every expected byte has left, then let the block go quiet.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (bytes_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_macro_count(input logic [COUNT_W-1:0] val);
        cur_count = val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MACRO_COUNT;
        pwdata  <= {23'b0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Index byte after an escape: mostly entries in use, some near the count boundary.
    function automatic logic [7:0] pick_index();
        int roll;
        int span;
        roll = $urandom_range(0, 99);
        span = (cur_count > ENTRIES) ? ENTRIES : int'(cur_count);
        if (roll < 55 && span > 0)
            return 8'($urandom_range(0, span - 1));
        if (roll < 65)
            return 8'(int'(cur_count) - (roll % 2));
        if (roll < 75)
            return ESCAPE_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    initial
    begin
        int ph;
        int k;
        int target;
        int roll;
        bit hold_done;

        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        cmd       = CMD_STREAM;
        data_byte = '0;
        entry     = '0;
        position  = '0;
        length    = '0;
        last      = 1'b0;
        hold_done = 1'b0;
        foreach (byte_written[i])
            byte_written[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: literals and escapes with an empty dictionary
        idle_level = 2;
        write_macro_count(9'd0);
        stream_byte(8'h00, 1'b0);
        stream_byte(8'hFF, 1'b1);
        stream_byte(ESCAPE_BYTE, 1'b0);
        stream_byte(8'h05, 1'b0);
        stream_byte(ESCAPE_BYTE, 1'b0);
        stream_byte(ESCAPE_BYTE, 1'b0);     // bad index that reopens an escape
        stream_byte(8'h41, 1'b0);
        stream_byte(ESCAPE_BYTE, 1'b1);     // trailing escape
        stream_byte(ESCAPE_BYTE, 1'b0);
        stream_byte(ESCAPE_BYTE, 1'b1);
        push_item(CMD_UNUSED, ESCAPE_BYTE, 6'h3F, 5'h1F, 6'h3F, 1'b1);
        write_macro_byte(6'd1, 5'd0, 8'hFF);
        write_macro_byte(6'd1, 5'd1, ESCAPE_BYTE);
        write_macro_byte(6'd1, 5'd2, 8'h00);
        define_macro(6'd0, 6'd0);           // empty macro
        define_macro(6'd1, 6'd3);
        define_macro(6'd63, 6'd2);
        settle();

        write_macro_count(9'd256);
        stream_byte(ESCAPE_BYTE, 1'b0);
        stream_byte(8'h00, 1'b0);
        stream_byte(ESCAPE_BYTE, 1'b0);
        stream_byte(8'h01, 1'b0);
        stream_byte(ESCAPE_BYTE, 1'b0);
        stream_byte(8'h3F, 1'b0);
        stream_byte(ESCAPE_BYTE, 1'b0);
        stream_byte(8'h02, 1'b0);           // entry never defined
        stream_byte(ESCAPE_BYTE, 1'b0);
        stream_byte(8'h40, 1'b0);           // below the count but past the dictionary
        stream_byte(ESCAPE_BYTE, 1'b0);
        stream_byte(8'hFF, 1'b1);
        stream_byte(ESCAPE_BYTE, 1'b0);
        write_macro_byte(6'd5, 5'd31, 8'hAA);   // command while an escape waits
        stream_byte(8'h01, 1'b1);
        define_macro(6'd2, 6'd63);          // length saturates
        stream_byte(ESCAPE_BYTE, 1'b0);
        stream_byte(8'h02, 1'b1);

        for (k = 0; k < PREFILL_DEFS; k++)
            define_macro(6'($urandom), 6'($urandom_range(1, MAX_MACRO_LEN)));

        for (ph = 0; ph < PHASES; ph++)
        begin
            settle();
            write_macro_count(PHASE_COUNT[ph]);
            idle_level = PHASE_IDLE[ph];
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                // long receiver hold-off while the sender keeps going
                if (ph == 1 && !hold_done && items_sent >= target - 70)
                begin
                    hold_req  = 1'b1;
                    hold_done = 1'b1;
                end
                roll = $urandom_range(0, 99);
                if (roll < 10)
                    write_macro_byte(6'($urandom), 5'($urandom), 8'($urandom));
                else if (roll < 15)
                    define_macro(6'($urandom), ($urandom_range(0, 9) < 7)
                                 ? 6'($urandom_range(0, MAX_MACRO_LEN)) : 6'($urandom));
                else if (roll < 17)
                    push_item(CMD_UNUSED, 8'($urandom), 6'($urandom), 5'($urandom),
                              6'($urandom), 1'($urandom));
                else if (roll < 67)
                begin
                    stream_byte(ESCAPE_BYTE, 1'b0);
                    stream_byte(pick_index(), $urandom_range(0, 7) == 0);
                end
                else
                    stream_byte(($urandom_range(0, 9) == 0) ? ESCAPE_BYTE : 8'($urandom),
                                $urandom_range(0, 7) == 0);
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("tb_escape_macro_byte_expander passed");
        else
            $display("tb_escape_macro_byte_expander failed");
        $finish;
    end

endmodule
